>>> sv/stawa_pkg.sv
package stawa_pkg;

   localparam int KEY_W = 50;
   localparam int CSR_W = 16;
   localparam int CSR_IDX_W = 2;

   localparam int DEF_SESSION_SLOTS = 64;
   localparam int DEF_BLOCK_SLOTS = 16;
   localparam int DEF_TIME_BITS = 32;

   localparam logic [15:0] TIMEOUT_RST = 16'd30;
   localparam logic [6:0] LIMIT_RST = 7'd64;
   localparam logic [6:0] RATE_RST = 7'd8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE = 2'd2;

   // operations
   localparam logic [2:0] FN_CREATE = 3'd0;
   localparam logic [2:0] FN_QUERY = 3'd1;
   localparam logic [2:0] FN_REMOVE = 3'd2;
   localparam logic [2:0] FN_GRACE = 3'd3;
   localparam logic [2:0] FN_TICK = 3'd4;
   localparam logic [2:0] FN_SHUTDOWN = 3'd5;
   localparam logic [2:0] FN_LOAD = 3'd6;
   localparam logic [2:0] FN_SPARE = 3'd7;

   // result codes
   localparam logic [2:0] ST_CREATED = 3'd0;
   localparam logic [2:0] ST_EXISTS = 3'd1;
   localparam logic [2:0] ST_BLOCKED = 3'd2;
   localparam logic [2:0] ST_LIMIT = 3'd3;
   localparam logic [2:0] ST_ACTIVE = 3'd4;
   localparam logic [2:0] ST_ABSENT = 3'd5;
   localparam logic [2:0] ST_REMOVED = 3'd6;
   localparam logic [2:0] ST_DONE = 3'd7;

   typedef struct packed {
      logic [2:0]       func;
      logic [KEY_W-1:0] subscriber_id;
      logic [3:0]       blocklist_slot;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [6:0]       active_count;
      logic [KEY_W-1:0] removed_id;
      logic [6:0]       expired_count;
      logic             last;
   } rsp_type;

endpackage

>>> sv/stawa_store.sv
module stawa_store import stawa_pkg::*; #(
   parameter int SESSION_SLOTS = DEF_SESSION_SLOTS,
   parameter int BLOCK_SLOTS = DEF_BLOCK_SLOTS,
   parameter int TIME_BITS = DEF_TIME_BITS,
   localparam int SW = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1,
   localparam int BW = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1
) (
   input  logic                 clock,
   input  logic                 e_we,
   input  logic [SW-1:0]        e_waddr,
   input  logic [KEY_W-1:0]     e_wkey,
   input  logic [TIME_BITS-1:0] e_wstart,
   input  logic                 e_re,
   input  logic [SW-1:0]        e_raddr,
   output logic [KEY_W-1:0]     e_rkey,
   output logic [TIME_BITS-1:0] e_rstart,
   input  logic                 b_we,
   input  logic [BW-1:0]        b_waddr,
   input  logic [KEY_W-1:0]     b_wkey,
   input  logic                 b_re,
   input  logic [BW-1:0]        b_raddr,
   output logic [KEY_W-1:0]     b_rkey
);

   logic [KEY_W-1:0]     ekey_mem [SESSION_SLOTS];
   logic [TIME_BITS-1:0] estart_mem [SESSION_SLOTS];
   logic [KEY_W-1:0]     bkey_mem [BLOCK_SLOTS];

   always_ff @(posedge clock) begin
      if (e_we) begin
         ekey_mem[e_waddr] <= e_wkey;
         estart_mem[e_waddr] <= e_wstart;
      end
      if (e_re) begin
         e_rkey <= ekey_mem[e_raddr];
         e_rstart <= estart_mem[e_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bkey_mem[b_waddr] <= b_wkey;
      end
      if (b_re) begin
         b_rkey <= bkey_mem[b_raddr];
      end
   end

endmodule

>>> sv/stawa_cmp.sv
module stawa_cmp import stawa_pkg::*; #(
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  logic [KEY_W-1:0]     key_a,
   input  logic [KEY_W-1:0]     key_b,
   input  logic [TIME_BITS-1:0] now,
   input  logic [TIME_BITS-1:0] start,
   input  logic [15:0]          timeout,
   output logic                 key_eq,
   output logic                 aged
);

   logic [TIME_BITS-1:0] age;

   assign key_eq = (key_a == key_b);
   assign age = now - start;   // wraps as the seconds counter does
   assign aged = (age > TIME_BITS'(timeout));

endmodule

>>> sv/session_table_with_aging_top.sv
// Session table with timeout aging: one operation at a time, sequenced over the slot memory.
// A create scans the blocklist and then the session slots; query, remove, grace and tick scan
// the session slots; shutdown emits one beat per removed session, or one beat if none is removed.
// Requests: ready again as the last beat loads, so no new op is taken before the last one is
// through, and any wait on rsp_ready holds it longer. The scan visits one slot per cycle.
// Reset (synchronous, active high) clears valid bits, count, seconds and reloads registers.
module session_table_with_aging_top import stawa_pkg::*; #(
   parameter int SESSION_SLOTS = DEF_SESSION_SLOTS,
   parameter int BLOCK_SLOTS = DEF_BLOCK_SLOTS,
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int SW = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;
   localparam int BW = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
   localparam int AW = ((SW > BW) ? SW : BW) + 1;   // scan counter, reaches the depth
   localparam int CW = $clog2(SESSION_SLOTS + 1);
   localparam int WW = CW + 8;                      // room for mixed-width compares

   typedef enum logic [2:0] {
      S_IDLE, S_BLK, S_ENT, S_TICK, S_SDSCAN, S_SDWAIT, S_SDEMIT, S_RESP
   } state_type;

   state_type state_ff;

   // configuration
   logic [15:0] timeout_ff;
   logic [6:0]  limit_ff;
   logic [6:0]  rate_ff;

   // table state held in flops
   logic [SESSION_SLOTS-1:0] ev_ff;
   logic [BLOCK_SLOTS-1:0]   bv_ff;
   logic [TIME_BITS-1:0]     now_ff;
   logic [CW-1:0]            count_ff;

   // operation in flight
   logic [2:0]       func_ff;
   logic [KEY_W-1:0] id_ff;
   logic [AW-1:0]    addr_ff;
   logic             pend_ff;
   logic [AW-1:0]    pidx_ff;
   logic             hit_ff;
   logic [SW-1:0]    hidx_ff;
   logic             free_ff;
   logic [SW-1:0]    fidx_ff;
   logic [CW-1:0]    rcnt_ff;
   logic [6:0]       sd_n_ff;
   logic [6:0]       sd_sent_ff;
   logic [CW-1:0]    sd_after_ff;

   // pending single result
   logic [2:0]       res_status_ff;
   logic [KEY_W-1:0] res_rid_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // memory and compare unit hookup
   logic                 e_we, e_re, b_we, b_re;
   logic [KEY_W-1:0]     e_rkey, b_rkey, cmp_key;
   logic [TIME_BITS-1:0] e_rstart;
   logic                 key_eq, aged;

   logic          out_free;
   logic          rsp_load;
   logic          in_scan_n, in_scan_b;
   logic [WW-1:0] cnt_w, lim_w, rate_w, n_w;
   logic          load_ok;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   // a beat is loaded into the output register this cycle
   assign rsp_load = out_free && ((state_ff == S_RESP) || (state_ff == S_SDEMIT));

   assign in_scan_n = (WW'(addr_ff) < WW'(SESSION_SLOTS));
   assign in_scan_b = (WW'(addr_ff) < WW'(BLOCK_SLOTS));

   assign cnt_w = WW'(count_ff);
   assign lim_w = WW'(limit_ff);
   assign rate_w = WW'(rate_ff);
   assign n_w = (rate_w < cnt_w) ? rate_w : cnt_w;
   assign load_ok = (WW'(req_data.blocklist_slot) < WW'(BLOCK_SLOTS));

   // read enables: the scan counter addresses both memories
   always_comb begin
      b_re = (state_ff == S_BLK) && in_scan_b;
      e_re = 1'b0;
      unique case (state_ff)
         S_ENT, S_TICK: e_re = in_scan_n;
         S_SDSCAN:      e_re = in_scan_n && ev_ff[addr_ff[SW-1:0]];
         default:       e_re = 1'b0;
      endcase
   end

   // new entry is written when a create settles in the lowest free slot
   assign e_we = (state_ff == S_ENT) && !in_scan_n && !pend_ff && (func_ff == FN_CREATE) &&
                 !hit_ff && (cnt_w < lim_w) && free_ff;
   assign b_we = req_valid && req_ready && (req_data.func == FN_LOAD) && load_ok;

   assign cmp_key = (state_ff == S_BLK) ? b_rkey : e_rkey;

   stawa_store #(
      .SESSION_SLOTS(SESSION_SLOTS),
      .BLOCK_SLOTS(BLOCK_SLOTS),
      .TIME_BITS(TIME_BITS)
   ) u_store (
      .clock(clock),
      .e_we(e_we),
      .e_waddr(fidx_ff),
      .e_wkey(id_ff),
      .e_wstart(now_ff),
      .e_re(e_re),
      .e_raddr(addr_ff[SW-1:0]),
      .e_rkey(e_rkey),
      .e_rstart(e_rstart),
      .b_we(b_we),
      .b_waddr(BW'(req_data.blocklist_slot)),
      .b_wkey(req_data.subscriber_id),
      .b_re(b_re),
      .b_raddr(addr_ff[BW-1:0]),
      .b_rkey(b_rkey)
   );

   // one comparator serves blocklist match, session match and expiry
   stawa_cmp #(
      .TIME_BITS(TIME_BITS)
   ) u_cmp (
      .key_a(id_ff),
      .key_b(cmp_key),
      .now(now_ff),
      .start(e_rstart),
      .timeout(timeout_ff),
      .key_eq(key_eq),
      .aged(aged)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         timeout_ff <= TIMEOUT_RST;
         limit_ff <= LIMIT_RST;
         rate_ff <= RATE_RST;
         ev_ff <= '0;
         bv_ff <= '0;
         now_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_TIMEOUT: timeout_ff <= csr_wdata;
               CSR_LIMIT:   limit_ff <= csr_wdata[6:0];
               CSR_RATE:    rate_ff <= csr_wdata[6:0];
               default:     ;
            endcase
         end

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         pend_ff <= b_re || e_re;
         // shutdown holds the slot it is emitting
         if ((state_ff != S_SDWAIT) && (state_ff != S_SDEMIT)) begin
            pidx_ff <= addr_ff;
         end

         unique case (state_ff)
            S_IDLE: begin
               addr_ff <= '0;
               hit_ff <= 1'b0;
               free_ff <= 1'b0;
               rcnt_ff <= '0;
               sd_sent_ff <= '0;
               if (req_valid) begin
                  func_ff <= req_data.func;
                  id_ff <= req_data.subscriber_id;
                  res_rid_ff <= '0;
                  res_status_ff <= ST_DONE;
                  unique case (req_data.func)
                     FN_CREATE: state_ff <= S_BLK;
                     FN_QUERY, FN_REMOVE, FN_GRACE: state_ff <= S_ENT;
                     FN_TICK: begin
                        now_ff <= now_ff + 1'b1;
                        state_ff <= S_TICK;
                     end
                     FN_SHUTDOWN: begin
                        sd_n_ff <= 7'(n_w);
                        sd_after_ff <= CW'(cnt_w - n_w);
                        state_ff <= (n_w == '0) ? S_RESP : S_SDSCAN;
                     end
                     FN_LOAD: begin
                        if (load_ok) begin
                           bv_ff[BW'(req_data.blocklist_slot)] <= 1'b1;
                        end
                        state_ff <= S_RESP;
                     end
                     default: state_ff <= S_IDLE;   // unused code: no result
                  endcase
               end
            end

            S_BLK: begin
               if (pend_ff && bv_ff[pidx_ff[BW-1:0]] && key_eq) begin
                  hit_ff <= 1'b1;
               end
               if (in_scan_b) begin
                  addr_ff <= addr_ff + 1'b1;
               end else if (!pend_ff) begin
                  addr_ff <= '0;
                  if (hit_ff) begin
                     res_status_ff <= ST_BLOCKED;
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_ENT;
                  end
               end
            end

            S_ENT: begin
               if (pend_ff && ev_ff[pidx_ff[SW-1:0]] && key_eq) begin
                  hit_ff <= 1'b1;
                  hidx_ff <= pidx_ff[SW-1:0];
               end
               if (in_scan_n) begin
                  // lowest free slot, noted as the scan passes it
                  if (!ev_ff[addr_ff[SW-1:0]] && !free_ff) begin
                     free_ff <= 1'b1;
                     fidx_ff <= addr_ff[SW-1:0];
                  end
                  addr_ff <= addr_ff + 1'b1;
               end else if (!pend_ff) begin
                  state_ff <= S_RESP;
                  unique case (func_ff)
                     FN_CREATE: begin
                        if (hit_ff) begin
                           res_status_ff <= ST_EXISTS;
                        end else if (cnt_w >= lim_w || !free_ff) begin
                           res_status_ff <= ST_LIMIT;
                        end else begin
                           ev_ff[fidx_ff] <= 1'b1;
                           count_ff <= count_ff + 1'b1;
                           res_status_ff <= ST_CREATED;
                        end
                     end
                     FN_QUERY: res_status_ff <= hit_ff ? ST_ACTIVE : ST_ABSENT;
                     default: begin
                        if (hit_ff) begin
                           ev_ff[hidx_ff] <= 1'b0;
                           if (count_ff != '0) begin
                              count_ff <= count_ff - 1'b1;
                           end
                           res_status_ff <= ST_REMOVED;
                           if (func_ff == FN_GRACE) begin
                              res_rid_ff <= id_ff;
                           end
                        end else begin
                           res_status_ff <= ST_ABSENT;
                        end
                     end
                  endcase
               end
            end

            S_TICK: begin
               if (pend_ff && ev_ff[pidx_ff[SW-1:0]] && aged) begin
                  ev_ff[pidx_ff[SW-1:0]] <= 1'b0;
                  if (count_ff != '0) begin
                     count_ff <= count_ff - 1'b1;
                  end
                  rcnt_ff <= rcnt_ff + 1'b1;
               end
               if (in_scan_n) begin
                  addr_ff <= addr_ff + 1'b1;
               end else if (!pend_ff) begin
                  state_ff <= S_RESP;
               end
            end

            S_SDSCAN: begin
               // skip free slots; the batch size guarantees a hit before the end
               if (in_scan_n) begin
                  addr_ff <= addr_ff + 1'b1;
                  if (ev_ff[addr_ff[SW-1:0]]) begin
                     state_ff <= S_SDWAIT;
                  end
               end else begin
                  state_ff <= S_IDLE;
               end
            end

            S_SDWAIT: begin
               state_ff <= S_SDEMIT;
            end

            S_SDEMIT: begin
               if (out_free) begin
                  rsp_data_ff.status <= ST_REMOVED;
                  rsp_data_ff.active_count <= 7'(sd_after_ff);
                  rsp_data_ff.removed_id <= e_rkey;
                  rsp_data_ff.expired_count <= '0;
                  rsp_data_ff.last <= (sd_sent_ff + 1'b1 == sd_n_ff);
                  ev_ff[pidx_ff[SW-1:0]] <= 1'b0;
                  if (count_ff != '0) begin
                     count_ff <= count_ff - 1'b1;
                  end
                  sd_sent_ff <= sd_sent_ff + 1'b1;
                  state_ff <= (sd_sent_ff + 1'b1 == sd_n_ff) ? S_IDLE : S_SDSCAN;
               end
            end

            S_RESP: begin
               if (out_free) begin
                  rsp_data_ff.status <= res_status_ff;
                  rsp_data_ff.active_count <= 7'(count_ff);
                  rsp_data_ff.removed_id <= res_rid_ff;
                  rsp_data_ff.expired_count <= 7'(rcnt_ff);
                  rsp_data_ff.last <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
